### rtl/core/aesbcm_pkg.sv
`default_nettype none
package aesbcm_pkg;

    localparam int unsigned BLK_W  = 128;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned VB_W   = 5;
    localparam int unsigned CIDX_W = 4;
    localparam int unsigned RK_DEPTH = 15;
    localparam int unsigned RK_AW  = 4;

    localparam logic [CIDX_W-1:0] CFG_KEY0 = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_KEY1 = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_KEY2 = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_KEY3 = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_IV_HI = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_IV_LO = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_KLEN = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_MODE = 4'd7;

    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_CFB_ENC = 3'd4;
    localparam logic [2:0] MODE_CFB_DEC = 3'd5;
    localparam logic [2:0] MODE_OFB     = 3'd6;
    localparam logic [2:0] MODE_CTR     = 3'd7;

    localparam logic [7:0] GF_POLY = 8'h1B;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_LOAD,
        S_INIT,
        S_ROUND,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [BLK_W-1:0] data;
        logic             done;
    } t_kwr;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

### rtl/core/aesbcm_in_if.sv
`default_nettype none
interface aesbcm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        first_block;
    logic [4:0]  valid_bytes;

    modport source (output valid, data_high, data_low, first_block, valid_bytes,
                    input ready);
    modport sink (input valid, data_high, data_low, first_block, valid_bytes,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/aesbcm_out_if.sv
`default_nettype none
interface aesbcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

### rtl/core/aesbcm_key_sched.sv
`default_nettype none
module aesbcm_key_sched (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [255:0]        i_key,
    input  wire logic [1:0]          i_key_length,
    output aesbcm_pkg::t_kwr         o_kwr
);
    import aesbcm_pkg::*;

    logic        r_busy;
    logic [5:0]  r_i;
    logic [2:0]  r_imod;
    logic [7:0]  r_rc;
    logic [31:0] r_win [8];
    logic [95:0] r_row;
    logic        r_we;
    logic        r_done;
    logic [RK_AW-1:0] r_addr;
    logic [BLK_W-1:0] r_data;

    logic [3:0]  nk;
    logic [5:0]  total;
    logic [2:0]  old_idx;
    logic [31:0] t;
    logic [31:0] w;
    logic        use_rc;

    assign o_kwr = '{we: r_we, addr: r_addr, data: r_data, done: r_done};

    always_comb begin
        case (i_key_length)
            KLEN_192: begin
                nk = 4'd6;
                total = 6'd52;
                old_idx = 3'd2;
            end
            KLEN_256: begin
                nk = 4'd8;
                total = 6'd60;
                old_idx = 3'd0;
            end
            default: begin
                nk = 4'd4;
                total = 6'd44;
                old_idx = 3'd4;
            end
        endcase
    end

    always_comb begin
        t = r_win[7];
        use_rc = 1'b0;
        if ({2'b00, r_i} < {4'b0000, nk}) begin
            w = i_key[255 - 32*r_i[2:0] -: 32];
        end else begin
            if (r_imod == 3'd0) begin
                t = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rc, 24'h000000};
                use_rc = 1'b1;
            end else if (nk == 4'd8 && r_imod == 3'd4) begin
                t = sub_word(r_win[7]);
            end
            w = r_win[old_idx] ^ t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_we <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_we <= (r_i[1:0] == 2'd3);
                if (r_i == total - 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i <= '0;
            r_imod <= '0;
            r_rc <= 8'h01;
        end else if (r_busy) begin
            for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
            r_win[7] <= w;
            r_row <= {r_row[63:0], w};
            r_addr <= r_i[5:2];
            r_data <= {r_row, w};
            r_i <= r_i + 6'd1;
            r_imod <= ({1'b0, r_imod} == nk - 4'd1) ? 3'd0 : r_imod + 3'd1;
            if (use_rc) r_rc <= xt(r_rc);
        end
    end
endmodule
`default_nettype wire

### rtl/core/aesbcm_round.sv
`default_nettype none
module aesbcm_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rk,
    input  wire logic         i_dec,
    input  wire logic         i_last,
    output logic [127:0]      o_state
);
    import aesbcm_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3;

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] x2, x4, x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        return (k[3] ? x8 : 8'h00) ^ (k[2] ? x4 : 8'h00) ^ (k[1] ? x2 : 8'h00)
             ^ (k[0] ? a : 8'h00);
    endfunction

    always_comb begin
        for (int b = 0; b < 16; b++) s[b] = i_state[127 - 8*b -: 8];
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_dec) t[r + 4*c] = RSBOX[s[r + 4*((c - r) & 3)]]
                                        ^ i_rk[127 - 8*(r + 4*c) -: 8];
                else       t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            if (i_dec) begin
                m[4*c]   = gm(a0, 4'he) ^ gm(a1, 4'hb) ^ gm(a2, 4'hd) ^ gm(a3, 4'h9);
                m[4*c+1] = gm(a0, 4'h9) ^ gm(a1, 4'he) ^ gm(a2, 4'hb) ^ gm(a3, 4'hd);
                m[4*c+2] = gm(a0, 4'hd) ^ gm(a1, 4'h9) ^ gm(a2, 4'he) ^ gm(a3, 4'hb);
                m[4*c+3] = gm(a0, 4'hb) ^ gm(a1, 4'hd) ^ gm(a2, 4'h9) ^ gm(a3, 4'he);
            end else begin
                m[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                m[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                m[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                m[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int b = 0; b < 16; b++) begin
            // Decryption adds the round key before the inverse column mix.
            if (i_dec) o_state[127 - 8*b -: 8] = i_last ? t[b] : m[b];
            else o_state[127 - 8*b -: 8] = (i_last ? t[b] : m[b])
                                            ^ i_rk[127 - 8*b -: 8];
        end
    end
endmodule
`default_nettype wire

### rtl/core/aes_block_cipher_modes_core.sv
`default_nettype none
// Channel  | Dir | Beat contents
// i_in     | in  | data_high, data_low, first_block, valid_bytes
// o_out    | out | result_high, result_low
// i_cfg_*  | in  | register index and 64-bit write data, no handshake
// A result becomes valid in the same cycle as the core is ready for the next block; a block
// is taken only once the one before it is through, with one AES round per cycle through a
// single round unit fed from the key memory.
// After a key or key length write, the next block first expands the schedule,
// one 32-bit word per cycle (44, 52 or 60 words).
// Reset is synchronous; the round key memory is not cleared.
// A finished result waits in the output register, so the next block is taken
// while it is unread; the cipher stalls at its last step only if it is still full.
module aes_block_cipher_modes_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    aesbcm_in_if.sink        i_in,
    aesbcm_out_if.source     o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import aesbcm_pkg::*;

    t_state r_state, n_state;
    logic [255:0] r_key;
    logic [127:0] r_iv;
    logic [1:0]   r_klen;
    logic [2:0]   r_mode;
    logic         r_ks_valid;
    logic [127:0] r_chain;
    logic [127:0] r_blk;
    logic [127:0] r_din;
    logic [127:0] r_mask;
    logic         r_dec;
    logic [3:0]   r_nr;
    logic [3:0]   r_step;
    logic [127:0] r_s;
    logic [127:0] r_rk_q;
    logic [127:0] r_rk_mem [RK_DEPTH];
    logic         r_ovalid;
    logic [127:0] r_res;

    logic         accept;
    logic         kstart;
    logic [3:0]   rd_k;
    logic [RK_AW-1:0] rd_addr;
    logic         out_free;
    logic         last;
    logic [127:0] round_out;
    logic [127:0] cb;
    logic [127:0] din;
    logic [127:0] n_res;
    logic [127:0] n_chain;
    logic [127:0] stream;
    logic [3:0]   nr_in;
    logic         dec_in;
    t_kwr         kwr;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign last     = (r_step == r_nr);
    assign cb       = i_in.first_block ? r_iv : r_chain;
    assign din      = {i_in.data_high, i_in.data_low};
    assign nr_in    = (r_klen == KLEN_192) ? 4'd12 : (r_klen == KLEN_256) ? 4'd14 : 4'd10;
    assign dec_in   = (r_mode == MODE_ECB_DEC) || (r_mode == MODE_CBC_DEC);
    assign stream   = (r_din ^ r_s) & r_mask;

    aesbcm_key_sched u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (kstart),
        .i_key        (r_key),
        .i_key_length (r_klen),
        .o_kwr        (kwr)
    );

    aesbcm_round u_round (
        .i_state (r_s),
        .i_rk    (r_rk_q),
        .i_dec   (r_dec),
        .i_last  (last),
        .o_state (round_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = r_ks_valid ? S_LOAD : S_KEXP;
            S_KEXP:  if (kwr.done) n_state = S_LOAD;
            S_LOAD:  n_state = S_INIT;
            S_INIT:  n_state = S_ROUND;
            S_ROUND: if (last) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        kstart = 1'b0;
        rd_k = 4'd0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                kstart = accept && !r_ks_valid;
            end
            S_INIT:  rd_k = 4'd1;
            S_ROUND: rd_k = last ? 4'd0 : r_step + 4'd1;
            default: rd_k = 4'd0;
        endcase
        // Decryption walks the round keys from the top down.
        rd_addr = r_dec ? r_nr - rd_k : rd_k;
    end

    always_ff @(posedge i_clk) begin
        if (kwr.we) r_rk_mem[kwr.addr] <= kwr.data;
        r_rk_q <= r_rk_mem[rd_addr];
    end

    always_comb begin
        n_res = r_s;
        n_chain = r_chain;
        case (r_mode)
            MODE_ECB_ENC, MODE_ECB_DEC: n_res = r_s;
            MODE_CBC_ENC: n_chain = r_s;
            MODE_CBC_DEC: begin
                n_res = r_s ^ r_chain;
                n_chain = r_din;
            end
            MODE_CFB_ENC: begin
                n_res = stream;
                n_chain = stream;
            end
            MODE_CFB_DEC: begin
                n_res = stream;
                n_chain = r_din & r_mask;
            end
            MODE_OFB: begin
                n_res = stream;
                n_chain = r_s;
            end
            MODE_CTR: begin
                n_res = stream;
                n_chain = r_chain + 128'd1;
            end
            default: n_res = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key <= '0;
            r_iv <= '0;
            r_klen <= '0;
            r_mode <= '0;
            r_ks_valid <= 1'b0;
            r_chain <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY0: begin r_key[255:192] <= i_cfg_data; r_ks_valid <= 1'b0; end
                    CFG_KEY1: begin r_key[191:128] <= i_cfg_data; r_ks_valid <= 1'b0; end
                    CFG_KEY2: begin r_key[127:64]  <= i_cfg_data; r_ks_valid <= 1'b0; end
                    CFG_KEY3: begin r_key[63:0]    <= i_cfg_data; r_ks_valid <= 1'b0; end
                    CFG_IV_HI: r_iv[127:64] <= i_cfg_data;
                    CFG_IV_LO: r_iv[63:0] <= i_cfg_data;
                    CFG_KLEN: begin r_klen <= i_cfg_data[1:0]; r_ks_valid <= 1'b0; end
                    CFG_MODE: r_mode <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (kwr.done) r_ks_valid <= 1'b1;
            if (accept) r_chain <= cb;
            if (r_state == S_FIN && out_free) begin
                r_chain <= n_chain;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_din <= din;
            r_dec <= dec_in;
            r_nr <= nr_in;
            for (int b = 0; b < 16; b++)
                r_mask[127 - 8*b -: 8] <= (5'(b) < i_in.valid_bytes) ? 8'hFF : 8'h00;
            case (r_mode)
                MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_DEC: r_blk <= din;
                MODE_CBC_ENC: r_blk <= din ^ cb;
                default: r_blk <= cb;
            endcase
        end
        case (r_state)
            S_INIT: begin
                r_s <= r_blk ^ r_rk_q;
                r_step <= 4'd1;
            end
            S_ROUND: begin
                r_s <= round_out;
                r_step <= r_step + 4'd1;
            end
            default: ;
        endcase
        if (r_state == S_FIN && out_free) r_res <= n_res;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.result_high = r_res[127:64];
    assign o_out.result_low = r_res[63:0];

    a_kwr_in_kexp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kwr.we |-> (r_state == S_KEXP))
        else $error("round key written outside key expansion");
    a_fast_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_ks_valid) |=> (r_state == S_LOAD))
        else $error("valid schedule did not skip expansion");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_step <= r_nr && r_step != 4'd0))
        else $error("round counter out of range");
endmodule
`default_nettype wire

### dv/aesbcm_checker.sv
module aesbcm_checker
    import aesbcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    aesbcm_in_if.sink        i_in,
    aesbcm_out_if.sink       i_out,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_bytes [16];

    logic [63:0]  key_reg [4];
    logic [63:0]  iv_hi, iv_lo;
    logic [1:0]   klen;
    logic [2:0]   mode;
    logic [127:0] rk_tbl [15];
    logic         sched_ok;
    t_bytes       chain;
    logic [7:0]   inv_box [256];
    logic [127:0] expected_blocks [$];
    int           fails;

    assign o_fail_count = fails;

    initial begin
        o_pending = 0;
        for (int i = 0; i < 256; i++) begin
            inv_box[SBOX[i]] = i[7:0];
        end
    end

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = dbl(a);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic int nrounds();
        return klen == KLEN_192 ? 12 : klen == KLEN_256 ? 14 : 10;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] t);
        return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    task automatic build_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        int nk, total;
        nk = klen == KLEN_192 ? 6 : klen == KLEN_256 ? 8 : 4;
        total = 4 * (nrounds() + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++) begin
            w[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        end
        for (int i = nk; i < total; i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i < total; i++) begin
            rk_tbl[i / 4][127 - 32 * (i % 4) -: 32] = w[i];
        end
        sched_ok = 1;
    endtask

    function automatic void mix_key(ref t_bytes s, input int r);
        for (int i = 0; i < 16; i++) s[i] ^= rk_tbl[r][127 - 8 * i -: 8];
    endfunction

    function automatic t_bytes cipher_fwd(input t_bytes s);
        t_bytes t;
        logic [7:0] a0, a1, a2, a3;
        int nr;
        nr = nrounds();
        mix_key(s, 0);
        for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
            if (rnd < nr) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end else begin
                s = t;
            end
            mix_key(s, rnd);
        end
        return s;
    endfunction

    function automatic t_bytes cipher_inv(input t_bytes s);
        t_bytes t;
        logic [7:0] a0, a1, a2, a3;
        int nr;
        nr = nrounds();
        mix_key(s, nr);
        for (int rnd = nr - 1; rnd >= 0; rnd--) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r + 4 * ((c + r) % 4)] = inv_box[s[r + 4 * c]];
            s = t;
            mix_key(s, rnd);
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d)
                               ^ gf_mul(a3, 8'h09);
                    s[4*c+1] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b)
                               ^ gf_mul(a3, 8'h0d);
                    s[4*c+2] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e)
                               ^ gf_mul(a3, 8'h0b);
                    s[4*c+3] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09)
                               ^ gf_mul(a3, 8'h0e);
                end
            end
        end
        return s;
    endfunction

    function automatic t_bytes to_bytes(input logic [127:0] v);
        t_bytes b;
        for (int i = 0; i < 16; i++) b[i] = v[127 - 8 * i -: 8];
        return b;
    endfunction

    function automatic logic [127:0] from_bytes(input t_bytes b);
        logic [127:0] v;
        for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = b[i];
        return v;
    endfunction

    task automatic predict_block(input logic [127:0] blk, input logic first,
                                 input logic [4:0] vb);
        t_bytes d, x, ks, res;
        int n;
        n = vb > 16 ? 16 : vb;
        if (!sched_ok) build_schedule();
        d = to_bytes(blk);
        if (first) chain = to_bytes({iv_hi, iv_lo});
        case (mode)
            MODE_ECB_ENC: res = cipher_fwd(d);
            MODE_ECB_DEC: res = cipher_inv(d);
            MODE_CBC_ENC: begin
                for (int i = 0; i < 16; i++) x[i] = d[i] ^ chain[i];
                res = cipher_fwd(x);
                chain = res;
            end
            MODE_CBC_DEC: begin
                x = cipher_inv(d);
                for (int i = 0; i < 16; i++) res[i] = x[i] ^ chain[i];
                chain = d;
            end
            default: begin
                ks = cipher_fwd(chain);
                for (int i = 0; i < 16; i++) begin
                    res[i] = i < n ? d[i] ^ ks[i] : 8'h00;
                    if (i >= n) d[i] = 8'h00;
                end
                if (mode == MODE_CFB_ENC) chain = res;
                else if (mode == MODE_CFB_DEC) chain = d;
                else if (mode == MODE_OFB) chain = ks;
                else chain = to_bytes(from_bytes(chain) + 128'd1);
            end
        endcase
        expected_blocks.push_back(from_bytes(res));
    endtask

    logic [127:0] want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_reg = '{default: '0};
            iv_hi = 0;
            iv_lo = 0;
            klen = 0;
            mode = 0;
            sched_ok = 0;
            chain = '{default: '0};
            fails = 0;
            expected_blocks.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result beat %h_%h", i_out.result_high, i_out.result_low);
                    fails++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_out.result_high !== want[127:64]) begin
                        $error("result_high expected %h actual %h", want[127:64],
                               i_out.result_high);
                        fails++;
                    end
                    if (i_out.result_low !== want[63:0]) begin
                        $error("result_low expected %h actual %h", want[63:0],
                               i_out.result_low);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_block({i_in.data_high, i_in.data_low}, i_in.first_block,
                              i_in.valid_bytes);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                        key_reg[i_cfg_index[1:0]] = i_cfg_data;
                        sched_ok = 0;
                    end
                    CFG_IV_HI: iv_hi = i_cfg_data;
                    CFG_IV_LO: iv_lo = i_cfg_data;
                    CFG_KLEN: begin
                        klen = i_cfg_data[1:0];
                        sched_ok = 0;
                    end
                    CFG_MODE: mode = i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_blocks.size();
    end
endmodule

### dv/tb_top.sv
module tb_top;
    import aesbcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [3:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;
    int          fail_count;
    int          pending;
    int          sent;

    aesbcm_in_if  in_ch();
    aesbcm_out_if out_ch();

    always #5 i_clk = ~i_clk;

    aes_block_cipher_modes_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    aesbcm_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        in_ch.valid = 0;
        in_ch.data_high = 0;
        in_ch.data_low = 0;
        in_ch.first_block = 0;
        in_ch.valid_bytes = 5'd16;
        out_ch.ready = 0;
    end

    // The receiver stalls a random number of cycles before each beat it takes.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic first, input logic [4:0] vb);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap) @(posedge i_clk);
        in_ch.valid <= 1;
        in_ch.data_high <= hi;
        in_ch.data_low <= lo;
        in_ch.first_block <= first;
        in_ch.valid_bytes <= vb;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 0;
        @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 3))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [4:0] pick_vb();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 5'd16;
        if (r == 5) return 5'($urandom_range(17, 31));
        if (r == 6) return 5'd0;
        return 5'($urandom_range(1, 15));
    endfunction

    task automatic setup(input logic [1:0] kl, input logic [2:0] m, input logic extreme);
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_KEY0 + 4'(k),
                      extreme ? ($urandom_range(0, 1) ? 64'h0 : '1) : rand64());
        end
        write_reg(CFG_IV_HI, extreme ? '1 : rand64());
        write_reg(CFG_IV_LO, extreme ? '1 : rand64());
        write_reg(CFG_KLEN, {62'h0, kl});
        write_reg(CFG_MODE, {61'h0, m});
    endtask

    initial begin
        logic [2:0] m;
        logic [1:0] kl;
        int run_len;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: all-zero key at reset, then each mode with extreme data and tails.
        send_block(64'h0, 64'h0, 1'b1, 5'd16);
        drain();
        write_reg(4'd9, 64'h1234);
        for (int mi = 0; mi < 8; mi++) begin
            setup(mi % 4 == 3 ? 2'd3 : 2'(mi % 3), 3'(mi), mi < 2);
            send_block('1, '1, 1'b1, 5'd16);
            send_block(64'h0, 64'h0, 1'(mi % 2), mi < 4 ? 5'd3 : 5'd0);
            send_block(rand64(), rand64(), 1'b0, mi == 7 ? 5'd31 : 5'd7);
            drain();
        end
        // CTR counter wrap from an all-ones IV.
        setup(KLEN_256, MODE_CTR, 1'b1);
        send_block(rand64(), rand64(), 1'b1, 5'd16);
        send_block(rand64(), rand64(), 1'b0, 5'd16);
        drain();

        while (sent < 1650) begin
            kl = 2'($urandom_range(0, 3));
            m = 3'($urandom_range(0, 7));
            setup(kl, m, $urandom_range(0, 9) == 0);
            run_len = $urandom_range(5, 40);
            for (int i = 0; i < run_len; i++) begin
                send_block(edge64(), edge64(), i == 0 || $urandom_range(0, 15) == 0,
                           pick_vb());
                // Occasionally hold off until every result is back.
                if ($urandom_range(0, 40) == 0) begin
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
